### hw/rtl/kls_pkg.sv
// Shared types and constants for the k-th smallest level select block.
// No dependencies; every other file in hw/rtl but kls_job_queue refers to this package.
package kls_pkg;

    localparam int ENERGY_W        = 32;   // Q16.16 level width
    localparam int FILL_W          = 9;    // width of the k field
    localparam int STATUS_W        = 2;
    localparam int DEF_MAX_LEVELS  = 256;

    // -665.0 in Q16.16, returned when k exceeds the set size
    localparam logic [ENERGY_W-1:0] ERR_LEVEL = 32'hFD67_0000;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 2'd0,
        ST_ZERO_COUNT = 2'd1,
        ST_TOO_BIG    = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_READ_V,
        BK_SCAN,
        BK_DRAIN,
        BK_DECIDE,
        BK_EMIT
    } t_back_state;

endpackage

### hw/rtl/kls_front.sv
// Front end: accepts items, writes levels into the back end's store and
// classifies the request carried by the last item. Depends on kls_pkg.
module kls_front #(
    parameter int MAX_LEVELS = kls_pkg::DEF_MAX_LEVELS
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_valid,
    output logic                                    o_stall,
    input  logic signed [kls_pkg::ENERGY_W-1:0]     i_energy,
    input  logic        [kls_pkg::FILL_W-1:0]       i_fill_count,
    input  logic                                    i_last,
    // store write port
    output logic                                    o_wr_en,
    output logic [$clog2(MAX_LEVELS)-1:0]           o_wr_addr,
    output logic signed [kls_pkg::ENERGY_W-1:0]     o_wr_data,
    // job queue push side
    output logic                                    o_push,
    output logic [kls_pkg::STATUS_W+2*$clog2(MAX_LEVELS+1)-1:0] o_job,
    input  logic                                    i_q_full,
    // back end done with the store
    input  logic                                    i_release
);

    localparam int CW = $clog2(MAX_LEVELS + 1);
    localparam int AW = $clog2(MAX_LEVELS);
    localparam int KW = (kls_pkg::FILL_W > CW) ? kls_pkg::FILL_W : CW;

    logic [CW-1:0]    r_count, n_count;
    logic             r_busy, n_busy;
    logic             accept;
    logic             room;
    logic [CW-1:0]    cnt_sat;
    logic [CW-1:0]    rank;
    kls_pkg::t_status status;

    assign o_stall = r_busy || i_q_full;
    assign accept  = i_valid && !o_stall;
    assign room    = (r_count < CW'(MAX_LEVELS));

    always_comb begin
        cnt_sat = room ? (r_count + CW'(1)) : r_count;

        if (i_fill_count == '0) begin
            status = kls_pkg::ST_ZERO_COUNT;
        end else if (KW'(i_fill_count) > KW'(cnt_sat)) begin
            status = kls_pkg::ST_TOO_BIG;
        end else begin
            status = kls_pkg::ST_OK;
        end
        rank = (i_fill_count == '0) ? CW'(1) : CW'(i_fill_count);

        o_wr_en   = accept && room;
        o_wr_addr = r_count[AW-1:0];
        o_wr_data = i_energy;
        o_push    = accept && i_last;
        o_job     = {status, rank, cnt_sat};

        n_count = r_count;
        n_busy  = r_busy;
        if (i_release) begin
            n_busy = 1'b0;
        end
        if (accept) begin
            if (i_last) begin
                n_count = '0;
                n_busy  = 1'b1;
            end else begin
                n_count = cnt_sat;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_busy  <= 1'b0;
        end else begin
            r_count <= n_count;
            r_busy  <= n_busy;
        end
    end

endmodule

### hw/rtl/kls_job_queue.sv
// Two-entry queue of selection jobs between front and back end.
// Depends on nothing beyond its width parameter.
module kls_job_queue #(
    parameter int WIDTH = 20
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_avail,
    output logic [WIDTH-1:0] o_data
);

    logic [WIDTH-1:0] r_data [2];
    logic             r_wr_ptr, n_wr_ptr;
    logic             r_rd_ptr, n_rd_ptr;
    logic [1:0]       r_cnt, n_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_avail = (r_cnt != 2'd0);
    assign o_data  = r_data[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_avail;

    always_comb begin
        n_wr_ptr = do_push ? !r_wr_ptr : r_wr_ptr;
        n_rd_ptr = do_pop ? !r_rd_ptr : r_rd_ptr;
        n_cnt    = r_cnt;
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_data[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

endmodule

### hw/rtl/kls_back.sv
// Back end: level store, rank-count selection sequencer and output register.
// Depends on kls_pkg.
module kls_back #(
    parameter int MAX_LEVELS = kls_pkg::DEF_MAX_LEVELS
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    // store write port from the front end
    input  logic                                    i_wr_en,
    input  logic [$clog2(MAX_LEVELS)-1:0]           i_wr_addr,
    input  logic signed [kls_pkg::ENERGY_W-1:0]     i_wr_data,
    // job queue pop side
    input  logic                                    i_job_avail,
    input  logic [kls_pkg::STATUS_W+2*$clog2(MAX_LEVELS+1)-1:0] i_job,
    output logic                                    o_pop,
    output logic                                    o_release,
    // result channel
    output logic                                    o_valid,
    input  logic                                    i_stall,
    output logic signed [kls_pkg::ENERGY_W-1:0]     o_level,
    output logic        [kls_pkg::STATUS_W-1:0]     o_status
);

    localparam int CW = $clog2(MAX_LEVELS + 1);
    localparam int AW = $clog2(MAX_LEVELS);
    localparam int JW = kls_pkg::STATUS_W + 2 * CW;

    logic signed [kls_pkg::ENERGY_W-1:0] r_mem [MAX_LEVELS];
    logic signed [kls_pkg::ENERGY_W-1:0] r_rd_data;
    logic [AW-1:0]                       rd_addr;

    kls_pkg::t_back_state r_state, n_state;
    kls_pkg::t_status     r_st, n_st;
    logic [CW-1:0]        r_n, n_n;
    logic [CW-1:0]        r_rank, n_rank;
    logic [AW-1:0]        r_i, n_i;
    logic [AW-1:0]        r_j, n_j;
    logic [CW-1:0]        r_below, n_below;
    logic [CW-1:0]        r_same, n_same;
    logic signed [kls_pkg::ENERGY_W-1:0] r_v, n_v;
    logic signed [kls_pkg::ENERGY_W-1:0] r_res, n_res;
    logic                 r_take_v;
    logic                 r_cmp;
    logic                 r_out_vld, n_out_vld;
    logic signed [kls_pkg::ENERGY_W-1:0] r_out_level;
    logic [kls_pkg::STATUS_W-1:0]        r_out_status;
    logic                 out_load;
    logic                 out_free;
    logic                 hit;
    logic [CW:0]          upper;

    // level store: written by the front end, read one entry a cycle here
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[rd_addr];
    end

    assign out_free = !r_out_vld || !i_stall;
    assign upper    = {1'b0, r_below} + {1'b0, r_same};
    assign hit      = (r_below < r_rank) && ({1'b0, r_rank} <= upper);

    always_comb begin
        n_state   = r_state;
        n_st      = r_st;
        n_n       = r_n;
        n_rank    = r_rank;
        n_i       = r_i;
        n_j       = r_j;
        n_below   = r_below;
        n_same    = r_same;
        n_v       = r_take_v ? r_rd_data : r_v;
        n_res     = r_res;
        o_pop     = 1'b0;
        o_release = 1'b0;
        out_load  = 1'b0;
        rd_addr   = (r_state == kls_pkg::BK_READ_V) ? r_i : r_j;

        // one comparison per cycle against the candidate
        if (r_cmp) begin
            if (r_rd_data < r_v) begin
                n_below = r_below + CW'(1);
            end else if (r_rd_data == r_v) begin
                n_same = r_same + CW'(1);
            end
        end

        unique case (r_state)
            kls_pkg::BK_IDLE: begin
                if (i_job_avail) begin
                    o_pop   = 1'b1;
                    n_st    = kls_pkg::t_status'(i_job[JW-1 -: kls_pkg::STATUS_W]);
                    n_rank  = i_job[2*CW-1 -: CW];
                    n_n     = i_job[CW-1:0];
                    n_i     = '0;
                    n_below = '0;
                    n_same  = '0;
                    if (n_st == kls_pkg::ST_TOO_BIG) begin
                        n_res   = kls_pkg::ERR_LEVEL;
                        n_state = kls_pkg::BK_EMIT;
                    end else begin
                        n_state = kls_pkg::BK_READ_V;
                    end
                end
            end
            kls_pkg::BK_READ_V: begin
                n_j     = '0;
                n_state = kls_pkg::BK_SCAN;
            end
            kls_pkg::BK_SCAN: begin
                if (CW'(r_j) == r_n - CW'(1)) begin
                    n_state = kls_pkg::BK_DRAIN;
                end else begin
                    n_j = r_j + AW'(1);
                end
            end
            kls_pkg::BK_DRAIN: begin
                n_state = kls_pkg::BK_DECIDE;
            end
            kls_pkg::BK_DECIDE: begin
                if (hit || (CW'(r_i) == r_n - CW'(1))) begin
                    n_res   = r_v;
                    n_state = kls_pkg::BK_EMIT;
                end else begin
                    n_i     = r_i + AW'(1);
                    n_below = '0;
                    n_same  = '0;
                    n_state = kls_pkg::BK_READ_V;
                end
            end
            kls_pkg::BK_EMIT: begin
                if (out_free) begin
                    out_load  = 1'b1;
                    o_release = 1'b1;
                    n_state   = kls_pkg::BK_IDLE;
                end
            end
            default: begin
                n_state = kls_pkg::BK_IDLE;
            end
        endcase

        n_out_vld = out_load || (r_out_vld && i_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= kls_pkg::BK_IDLE;
            r_take_v  <= 1'b0;
            r_cmp     <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_take_v  <= (r_state == kls_pkg::BK_READ_V);
            r_cmp     <= (r_state == kls_pkg::BK_SCAN);
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_st    <= n_st;
        r_n     <= n_n;
        r_rank  <= n_rank;
        r_i     <= n_i;
        r_j     <= n_j;
        r_below <= n_below;
        r_same  <= n_same;
        r_v     <= n_v;
        r_res   <= n_res;
        if (out_load) begin
            r_out_level  <= r_res;
            r_out_status <= r_st;
        end
    end

    assign o_valid  = r_out_vld;
    assign o_level  = r_out_level;
    assign o_status = r_out_status;

endmodule

### hw/rtl/kth_smallest_level_select_core.sv
// K-th smallest level select, top level: front end, job queue, back end.
// Depends on kls_pkg, kls_front, kls_job_queue and kls_back.
//
// Loads a set of signed Q16.16 levels, one item per cycle, into an on-chip
// store of MAX_LEVELS entries; the item with i_last high closes the set and
// carries k in i_fill_count. One result item follows each set: the k-th
// smallest level with status 0, the minimum with status 1 when k is zero,
// or -665.0 with status 2 when k exceeds the levels stored. Levels beyond
// MAX_LEVELS in one set are dropped. Loading runs at one item per cycle
// while o_stall is low; after the last item the back end ranks candidates
// one at a time, each with a full pass over the store through its single
// read port, and a k that is too large skips the ranking. The input stalls
// from the last item until the result is in the output register; a result
// may wait there under i_stall without holding up the next set's loading.
module kth_smallest_level_select_core #(
    parameter int MAX_LEVELS = kls_pkg::DEF_MAX_LEVELS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // item input channel
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic signed [kls_pkg::ENERGY_W-1:0] i_energy,
    input  logic        [kls_pkg::FILL_W-1:0]   i_fill_count,
    input  logic                                i_last,
    // result channel
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [kls_pkg::ENERGY_W-1:0] o_level,
    output logic        [kls_pkg::STATUS_W-1:0] o_status
);

    localparam int CW = $clog2(MAX_LEVELS + 1);
    localparam int AW = $clog2(MAX_LEVELS);
    // job = {status, rank, set size}
    localparam int JW = kls_pkg::STATUS_W + 2 * CW;

    logic                                wr_en;
    logic [AW-1:0]                       wr_addr;
    logic signed [kls_pkg::ENERGY_W-1:0] wr_data;
    logic                                push;
    logic [JW-1:0]                       push_job;
    logic                                q_full;
    logic                                pop;
    logic                                job_avail;
    logic [JW-1:0]                       pop_job;
    logic                                release_buf;

    // Front end: store writes and k classification
    kls_front #(
        .MAX_LEVELS (MAX_LEVELS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_energy     (i_energy),
        .i_fill_count (i_fill_count),
        .i_last       (i_last),
        .o_wr_en      (wr_en),
        .o_wr_addr    (wr_addr),
        .o_wr_data    (wr_data),
        .o_push       (push),
        .o_job        (push_job),
        .i_q_full     (q_full),
        .i_release    (release_buf)
    );

    // Jobs waiting for the selection sequencer
    kls_job_queue #(
        .WIDTH (JW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_job),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_avail (job_avail),
        .o_data  (pop_job)
    );

    // Back end: store, rank counting, result register
    kls_back #(
        .MAX_LEVELS (MAX_LEVELS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wr_en     (wr_en),
        .i_wr_addr   (wr_addr),
        .i_wr_data   (wr_data),
        .i_job_avail (job_avail),
        .i_job       (pop_job),
        .o_pop       (pop),
        .o_release   (release_buf),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_level     (o_level),
        .o_status    (o_status)
    );

endmodule

### tb/tb.sv
`timescale 1ns / 100ps
// Self-checking bench for kth_smallest_level_select_core: random and directed level sets.
// Depends on kls_pkg and the core RTL only.
module tb;

    localparam int DEPTH       = kls_pkg::DEF_MAX_LEVELS;
    localparam int HOLD_AT     = 40;     // earliest result count for the long hold-off
    localparam int HOLD_FEED   = 60;     // items still queued so the sender keeps going
    localparam int HOLD_CYCLES = 3000;

    typedef logic signed [kls_pkg::ENERGY_W-1:0] t_level;
    typedef logic        [kls_pkg::FILL_W-1:0]   t_fill;

    typedef struct packed {
        t_level energy;
        t_fill  fill;
        logic   last;
    } t_lvl_item;

    typedef struct packed {
        t_level           level;
        kls_pkg::t_status status;
    } t_lvl_result;

    logic                               i_clk = 1'b0;
    logic                               i_rst_n = 1'b0;
    logic                               i_valid = 1'b0;
    logic                               o_stall;
    t_level                             i_energy = '0;
    t_fill                              i_fill_count = '0;
    logic                               i_last = 1'b0;
    logic                               o_valid;
    logic                               i_stall = 1'b0;
    t_level                             o_level;
    logic        [kls_pkg::STATUS_W-1:0] o_status;

    // stimulus feed and the levels the core is due to return
    t_lvl_item   level_feed[$];
    t_lvl_result due_levels[$];

    // shadow of the core's set store
    t_level      set_store[DEPTH];
    int unsigned set_fill = 0;

    int unsigned mismatches = 0;
    int unsigned items_loaded = 0;
    int unsigned results_seen = 0;
    int unsigned n_ok = 0, n_zero = 0, n_big = 0;
    int unsigned tx_wait = 0, rx_wait = 0;
    bit          tx_burst = 1'b0, rx_burst = 1'b0;
    bit          hold_done = 1'b0;

    kth_smallest_level_select_core i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_energy     (i_energy),
        .i_fill_count (i_fill_count),
        .i_last       (i_last),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_level      (o_level),
        .o_status     (o_status)
    );

    always #6 i_clk = ~i_clk;

    // k-th smallest (1-based) of the first n stored levels; duplicates keep their own rank
    function automatic t_level kth_of_store(int unsigned n, int unsigned k);
        t_level srt[DEPTH];
        t_level t;
        int j;
        for (int i = 0; i < n; i++) srt[i] = set_store[i];
        for (int i = 1; i < n; i++) begin
            t = srt[i];
            j = i - 1;
            while (j >= 0 && srt[j] > t) begin
                srt[j+1] = srt[j];
                j--;
            end
            srt[j+1] = t;
        end
        return srt[k-1];
    endfunction

    // Shadow of one accepted item; a closing item queues the level the core owes.
    function automatic void load_level(t_lvl_item it);
        t_lvl_result r;
        int unsigned k;
        k = 32'(it.fill);
        if (set_fill < DEPTH) begin
            set_store[set_fill] = it.energy;
            set_fill++;
        end
        if (it.last) begin
            if (k == 0) begin
                r.level  = kth_of_store(set_fill, 1);
                r.status = kls_pkg::ST_ZERO_COUNT;
                n_zero++;
            end else if (k > set_fill) begin
                r.level  = kls_pkg::ERR_LEVEL;
                r.status = kls_pkg::ST_TOO_BIG;
                n_big++;
            end else begin
                r.level  = kth_of_store(set_fill, k);
                r.status = kls_pkg::ST_OK;
                n_ok++;
            end
            set_fill = 0;
            due_levels.push_back(r);
        end
    endfunction

    function automatic t_level draw_level(int unsigned mode);
        case (mode)
            0: return $urandom;
            1: return $signed($urandom_range(0, 7)) - 4;     // narrow range, many ties
            default: begin
                case ($urandom_range(0, 4))
                    0: return 32'sh8000_0000;
                    1: return 32'sh7FFF_FFFF;
                    2: return '0;
                    3: return -1;
                    default: return kls_pkg::ERR_LEVEL;
                endcase
            end
        endcase
    endfunction

    task automatic push_item(t_level e, t_fill k, logic l);
        t_lvl_item it;
        it.energy = e;
        it.fill   = k;
        it.last   = l;
        level_feed.push_back(it);
    endtask

    // k rides on the last item; earlier items carry junk in the count field
    task automatic push_set(int unsigned n, int unsigned k, int unsigned mode);
        for (int unsigned i = 0; i < n; i++) begin
            if (i == n - 1) push_item(draw_level(mode), t_fill'(k), 1'b1);
            else push_item(draw_level(mode), t_fill'($urandom_range(0, 511)), 1'b0);
        end
    endtask

    // Mostly short sets so selection stays cheap, with a mix of k: valid, k = n,
    // zero, just past n and far past n (up to the field maximum).
    task automatic random_chunk(int unsigned n_items);
        int unsigned done;
        int unsigned n;
        int unsigned k;
        int unsigned sel;
        done = 0;
        while (done < n_items) begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
            sel = $urandom_range(0, 19);
            if (sel < 13) k = $urandom_range(1, n);
            else if (sel < 15) k = n;
            else if (sel < 17) k = 0;
            else if (sel < 19) k = $urandom_range(n + 1, n + 3);
            else k = $urandom_range(n + 1, 511);
            push_set(n, k, $urandom_range(0, 2));
            done += n;
        end
    endtask

    // sender holds back until the feed is empty and every result is back
    task automatic wait_drained();
        while (level_feed.size() != 0 || i_valid || due_levels.size() != 0)
            @(negedge i_clk);
    endtask

    // Sender: one item at a time from the feed, with a drawn gap after each, none in burst phases.
    always @(posedge i_clk) begin : tx_side
        t_lvl_item nxt;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            tx_wait <= 0;
        end else begin
            if (i_valid && !o_stall) begin
                items_loaded++;
                nxt.energy = i_energy;
                nxt.fill   = i_fill_count;
                nxt.last   = i_last;
                load_level(nxt);
            end
            if (!i_valid || !o_stall) begin
                if (tx_wait != 0) begin
                    tx_wait <= tx_wait - 1;
                    i_valid <= 1'b0;
                end else if (level_feed.size() != 0) begin
                    nxt = level_feed.pop_front();
                    i_energy     <= nxt.energy;
                    i_fill_count <= nxt.fill;
                    i_last       <= nxt.last;
                    i_valid      <= 1'b1;
                    tx_wait      <= tx_burst ? 0 : $urandom_range(0, 19);
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks each result, then stalls for a drawn number of cycles.
    // The stall count runs down every cycle, so it lands on busy and idle phases alike.
    always @(posedge i_clk) begin : rx_side
        t_lvl_result want;
        int unsigned w;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            rx_wait <= 0;
        end else begin
            w = rx_wait;
            if (w != 0) w--;
            if (o_valid && !i_stall) begin
                results_seen++;
                if (due_levels.size() == 0) begin
                    mismatches++;
                    $display("%0t: expected no result, actual level %h status %0d",
                             $time, o_level, o_status);
                end else begin
                    want = due_levels.pop_front();
                    if (o_level !== want.level) begin
                        mismatches++;
                        $display("%0t: level expected %h actual %h",
                                 $time, want.level, o_level);
                    end
                    if (o_status !== want.status) begin
                        mismatches++;
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, o_status);
                    end
                end
                w = rx_burst ? 0 : $urandom_range(0, 19);
                // one long hold-off while plenty is queued: the next set loads
                // behind a parked result and the input stalls
                if (!hold_done && results_seen >= HOLD_AT &&
                    level_feed.size() > HOLD_FEED) begin
                    w = HOLD_CYCLES;
                    hold_done = 1'b1;
                end
            end
            rx_wait <= w;
            i_stall <= (w != 0);
        end
    end

    initial begin
        int unsigned k;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: single-item sets at both extremes, zero count, k one too large
        push_item(32'sh7FFF_FFFF, 9'd1, 1'b1);
        push_item(32'sh8000_0000, 9'd0, 1'b1);
        push_item(32'sd12345, 9'd2, 1'b1);
        // extremes mixed, k = n, junk count on inner items
        push_item(32'sh8000_0000, 9'd511, 1'b0);
        push_item(32'sh7FFF_FFFF, 9'd511, 1'b0);
        push_item(-32'sd1, 9'd300, 1'b0);
        push_item(32'sd0, 9'd4, 1'b1);
        // ties: sorted -3 -3 5 5 5, rank 3 is 5
        push_item(32'sd5, 9'd0, 1'b0);
        push_item(32'sd5, 9'd0, 1'b0);
        push_item(-32'sd3, 9'd0, 1'b0);
        push_item(32'sd5, 9'd0, 1'b0);
        push_item(-32'sd3, 9'd3, 1'b1);
        // field maximum for k
        push_item(32'sd1, 9'd0, 1'b0);
        push_item(32'sd2, 9'd0, 1'b0);
        push_item(32'sd3, 9'd511, 1'b1);
        // zero count with the minimum repeated
        push_item(-32'sd7, 9'd0, 1'b0);
        push_item(32'sd9, 9'd0, 1'b0);
        push_item(-32'sd7, 9'd0, 1'b1);
        // the error pattern as ordinary data
        push_item(kls_pkg::ERR_LEVEL, 9'd0, 1'b0);
        push_item(32'sd0, 9'd1, 1'b1);
        wait_drained();

        random_chunk(220);
        wait_drained();
        tx_burst = 1'b1;
        rx_burst = 1'b1;
        random_chunk(220);
        wait_drained();
        rx_burst = 1'b0;
        random_chunk(220);
        wait_drained();
        tx_burst = 1'b0;
        rx_burst = 1'b1;
        random_chunk(220);
        wait_drained();
        rx_burst = 1'b0;

        // full store, k = 256
        push_set(DEPTH, DEPTH, 0);
        // store full: two trailing minimums are dropped, the last one still closes the set
        k = $urandom_range(1, DEPTH);
        for (int i = 0; i < DEPTH; i++) push_item($urandom_range(0, 32'h7FFF_FFFF), 9'd0, 1'b0);
        push_item(32'sh8000_0000, 9'd0, 1'b0);
        push_item(32'sh8000_0000, t_fill'(k), 1'b1);
        // count saturates at the store size, so 257 is too large
        push_set(DEPTH + 6, DEPTH + 1, 0);
        wait_drained();

        repeat (40) @(posedge i_clk);
        $display("%0d items loaded, %0d results: %0d ranked, %0d zero-count, %0d too-large",
                 items_loaded, results_seen, n_ok, n_zero, n_big);
        $display("store-full sets, long receiver hold-off and burst phases included");
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #(24_000_000);
        $display("timeout: %0d results seen, %0d still due", results_seen, due_levels.size());
        $display("CHECK FAILED");
        $finish;
    end

endmodule
